// ----- rtl/core/life_generation_row_stream_macros.svh -----
`ifndef LIFE_GENERATION_ROW_STREAM_MACROS_SVH
`define LIFE_GENERATION_ROW_STREAM_MACROS_SVH

// same-cycle implication, sampled on clk and held off during reset
`define LGR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LGR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lgr_pkg.sv -----
package lgr_pkg;

	localparam int GRID_SIZE = 64;
	localparam int ROW_BITS = 64;
	localparam int NUM_W = 6;
	localparam int ROW_CNT_W = $clog2(GRID_SIZE + 1);

	localparam int BIRTH_COUNT = 3;
	localparam int SURVIVE_COUNT = 2;

	localparam logic [ROW_BITS-1:0] COL_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - GRID_SIZE);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [ROW_BITS-1:0] above;
		logic [ROW_BITS-1:0] here;
		logic [ROW_BITS-1:0] below;
		logic [NUM_W-1:0]    row_number;
		logic                top_border;
		logic                last;
	} lgr_entry_t;

	// next generation of the middle row, interior columns only
	function automatic logic [ROW_BITS-1:0] lgr_evolve(
		input logic [ROW_BITS-1:0] above,
		input logic [ROW_BITS-1:0] here,
		input logic [ROW_BITS-1:0] below
	);
		logic [ROW_BITS-1:0] res;
		logic [3:0] n;
		res = '0;
		for (int c = 1; c < GRID_SIZE - 1; c++) begin
			n = 4'(above[c-1]) + 4'(above[c]) + 4'(above[c+1])
			  + 4'(here[c-1]) + 4'(here[c+1])
			  + 4'(below[c-1]) + 4'(below[c]) + 4'(below[c+1]);
			if (n == 4'(BIRTH_COUNT) || (here[c] && n == 4'(SURVIVE_COUNT))) begin
				res[c] = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/core/lgr_if.sv -----
interface lgr_row_if;
	logic                           valid;
	logic                           ready;
	logic [lgr_pkg::ROW_BITS-1:0]   row_cells;
	logic                           frame_start;

	modport source (output valid, output row_cells, output frame_start, input ready);
	modport sink (input valid, input row_cells, input frame_start, output ready);
	modport monitor (input valid, input row_cells, input frame_start, input ready);
endinterface

interface lgr_result_if;
	logic                           valid;
	logic                           ready;
	logic [lgr_pkg::NUM_W-1:0]      row_number;
	logic [lgr_pkg::ROW_BITS-1:0]   next_cells;
	logic                           frame_end;

	modport source (output valid, output row_number, output next_cells, output frame_end,
		input ready);
	modport sink (input valid, input row_number, input next_cells, input frame_end,
		output ready);
	modport monitor (input valid, input row_number, input next_cells, input frame_end,
		input ready);
endinterface

// ----- rtl/core/lgr_front.sv -----
module lgr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	lgr_row_if.sink              row_in,
	output logic                 push_valid,
	input  logic                 push_ready,
	output lgr_pkg::lgr_entry_t  push_data
);

	logic [lgr_pkg::ROW_BITS-1:0]  upper_q;
	logic [lgr_pkg::ROW_BITS-1:0]  middle_q;
	logic [lgr_pkg::ROW_CNT_W-1:0] rows_seen_q;
	logic [lgr_pkg::ROW_BITS-1:0]  row;
	logic                          start_grid;
	logic                          accept;

	assign row = row_in.row_cells & lgr_pkg::COL_MASK;
	assign start_grid = row_in.frame_start || rows_seen_q == '0
		|| rows_seen_q >= lgr_pkg::ROW_CNT_W'(lgr_pkg::GRID_SIZE);

	assign row_in.ready = push_ready;
	assign accept = row_in.valid && push_ready;
	assign push_valid = accept && !start_grid;

	always_comb begin
		push_data.above = upper_q;
		push_data.here = middle_q;
		push_data.below = row;
		push_data.row_number = lgr_pkg::NUM_W'(rows_seen_q - lgr_pkg::ROW_CNT_W'(1));
		push_data.top_border = rows_seen_q == lgr_pkg::ROW_CNT_W'(1);
		push_data.last = rows_seen_q == lgr_pkg::ROW_CNT_W'(lgr_pkg::GRID_SIZE - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= '0;
			middle_q <= '0;
			rows_seen_q <= '0;
		end else if (accept) begin
			if (start_grid) begin
				upper_q <= '0;
				rows_seen_q <= lgr_pkg::ROW_CNT_W'(1);
			end else begin
				upper_q <= middle_q;
				rows_seen_q <= rows_seen_q + lgr_pkg::ROW_CNT_W'(1);
			end
			middle_q <= row;
		end
	end

endmodule

// ----- rtl/core/lgr_queue.sv -----
module lgr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  lgr_pkg::lgr_entry_t  push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output lgr_pkg::lgr_entry_t  pop_data
);

	lgr_pkg::lgr_entry_t             mem_q [lgr_pkg::QUEUE_DEPTH];
	logic [lgr_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [lgr_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [lgr_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = count_q != lgr_pkg::QCNT_W'(lgr_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == lgr_pkg::QPTR_W'(lgr_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + lgr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == lgr_pkg::QPTR_W'(lgr_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + lgr_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + lgr_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - lgr_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/lgr_back.sv -----
module lgr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  lgr_pkg::lgr_entry_t  pop_data,
	lgr_result_if.source         res_out
);

	logic                          out_valid_q;
	logic [lgr_pkg::NUM_W-1:0]     row_number_q;
	logic [lgr_pkg::ROW_BITS-1:0]  next_cells_q;
	logic                          frame_end_q;
	logic                          second_q;
	logic                          load;
	logic [lgr_pkg::ROW_BITS-1:0]  evolved;

	assign load = !out_valid_q || res_out.ready;
	// the last entry stays at the head until its bottom-border result is loaded for output
	assign pop_ready = load && (second_q || (pop_valid && !pop_data.last));
	assign evolved = pop_data.top_border ? '0
		: lgr_pkg::lgr_evolve(pop_data.above, pop_data.here, pop_data.below)
			& lgr_pkg::COL_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q <= 1'b0;
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				second_q <= pop_data.last;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				row_number_q <= lgr_pkg::NUM_W'(lgr_pkg::GRID_SIZE - 1);
				next_cells_q <= '0;
				frame_end_q <= 1'b1;
			end else begin
				row_number_q <= pop_data.row_number;
				next_cells_q <= evolved;
				frame_end_q <= 1'b0;
			end
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.row_number = row_number_q;
	assign res_out.next_cells = next_cells_q;
	assign res_out.frame_end = frame_end_q;

endmodule

// ----- rtl/core/life_generation_row_stream.sv -----
// channel   | dir | payload                               | handshake
// row_in    | in  | row_cells[63:0], frame_start          | valid/ready
// res_out   | out | row_number[5:0], next_cells[63:0],    | valid/ready
//           |     | frame_end                             |
//
// one row item per cycle while res_out is ready; results are queued, then registered
// the final row of a grid gives two results, one after the other, from the back end
// a two-entry queue sits between row intake and the evolve stage, so a stalled
// output lets two more result-bearing rows in before row_in.ready falls
// arst_n clears the row history, row count, queue and output valid; no clearing pass

module life_generation_row_stream (
	input  logic           clk,
	input  logic           arst_n,
	lgr_row_if.sink        row_in,
	lgr_result_if.source   res_out
);

	logic                 push_valid;
	logic                 push_ready;
	lgr_pkg::lgr_entry_t  push_data;
	logic                 pop_valid;
	logic                 pop_ready;
	lgr_pkg::lgr_entry_t  pop_data;

	lgr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_in     (row_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lgr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	lgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_out   (res_out)
	);

endmodule

// ----- rtl/core/lgr_checker.sv -----
`include "life_generation_row_stream_macros.svh"

module lgr_checker (
	input  logic            clk,
	input  logic            arst_n,
	lgr_result_if.source    res_out
);

	// a held result keeps its payload
	`LGR_ASSERT_NEXT(a_res_hold, res_out.valid && !res_out.ready,
		res_out.valid && $stable(res_out.row_number) && $stable(res_out.next_cells)
			&& $stable(res_out.frame_end),
		"result changed while stalled")

	// bottom border row is always dead and carries the last index
	`LGR_ASSERT_NOW(a_end_dead, res_out.valid && res_out.frame_end,
		res_out.next_cells == '0
			&& res_out.row_number == lgr_pkg::NUM_W'(lgr_pkg::GRID_SIZE - 1),
		"frame end row not dead")

	// border columns never come alive
	`LGR_ASSERT_NOW(a_col_border, res_out.valid,
		!res_out.next_cells[0] && !res_out.next_cells[lgr_pkg::GRID_SIZE - 1],
		"border column alive")

	// top border row is always dead
	`LGR_ASSERT_NOW(a_top_dead, res_out.valid && res_out.row_number == '0,
		res_out.next_cells == '0, "top row not dead")

endmodule

bind life_generation_row_stream lgr_checker u_lgr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.res_out (res_out)
);
